// ===== sv/lir_pkg.sv =====
// Package for the linear interpolation resampler: constants, control types, microcode table.
package lir_pkg;

  localparam int SAMPLE_WIDTH_DEF    = 16;
  localparam int PHASE_FRAC_BITS_DEF = 16;
  localparam int RATE_W              = 21;
  localparam int CHAN_W              = 2;
  localparam int CFG_IDX_W           = 2;
  localparam int MAX_OUT             = 16;
  localparam int CNT_W               = $clog2(MAX_OUT + 1);
  localparam int UPC_W               = 3;

  localparam logic [CFG_IDX_W-1:0] REG_RATE_STEP     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_USED = CFG_IDX_W'(1);

  localparam logic [RATE_W-1:0] RATE_RST  = RATE_W'(65536);
  localparam logic [CHAN_W-1:0] CHAN_RST  = CHAN_W'(2);
  localparam logic [CHAN_W-1:0] CHAN_MONO = CHAN_W'(1);

  // microcode addresses
  localparam logic [UPC_W-1:0] U_WAIT = UPC_W'(0);
  localparam logic [UPC_W-1:0] U_LOAD = UPC_W'(1);
  localparam logic [UPC_W-1:0] U_DIFF = UPC_W'(2);
  localparam logic [UPC_W-1:0] U_TEST = UPC_W'(3);
  localparam logic [UPC_W-1:0] U_MUL  = UPC_W'(4);
  localparam logic [UPC_W-1:0] U_EMIT = UPC_W'(5);
  localparam logic [UPC_W-1:0] U_END  = UPC_W'(6);

  typedef enum logic [1:0] {
    W_NONE,
    W_IN,
    W_OUT
  } wait_e;

  typedef enum logic [1:0] {
    J_NEVER,
    J_ALWAYS,
    J_HAVE,
    J_DONE
  } jcond_e;

  typedef struct packed {
    logic in_rdy;
    logic ld_cur;
    logic ld_prev;
    logic set_have;
    logic ld_diff;
    logic init_ph;
    logic ld_prod;
    logic emit;
    logic fin;
  } ctl_t;

  typedef struct packed {
    wait_e            wt;
    jcond_e           jc;
    logic [UPC_W-1:0] target;
    ctl_t             ctl;
  } uword_t;

  typedef struct packed {
    logic             have_prev;
    logic             done;
    logic             out_busy;
    logic [CNT_W-1:0] n;
  } stat_t;

  function automatic uword_t ucode_rom(logic [UPC_W-1:0] addr);
    uword_t w;
    w        = '0;
    w.wt     = W_NONE;
    w.jc     = J_ALWAYS;
    w.target = U_WAIT;
    unique case (addr)
      U_WAIT: begin
        w.wt = W_IN;  w.jc = J_HAVE; w.target = U_DIFF;
        w.ctl.in_rdy = 1'b1; w.ctl.ld_cur = 1'b1;
      end
      U_LOAD: begin
        w.jc = J_ALWAYS; w.target = U_WAIT;
        w.ctl.ld_prev = 1'b1; w.ctl.set_have = 1'b1;
      end
      U_DIFF: begin
        w.jc = J_NEVER;
        w.ctl.ld_diff = 1'b1; w.ctl.init_ph = 1'b1;
      end
      U_TEST: begin
        w.jc = J_DONE; w.target = U_END;
      end
      U_MUL: begin
        w.jc = J_NEVER;
        w.ctl.ld_prod = 1'b1;
      end
      U_EMIT: begin
        w.wt = W_OUT; w.jc = J_ALWAYS; w.target = U_TEST;
        w.ctl.emit = 1'b1;
      end
      U_END: begin
        w.jc = J_ALWAYS; w.target = U_WAIT;
        w.ctl.fin = 1'b1; w.ctl.ld_prev = 1'b1;
      end
      default: begin
        w.jc = J_ALWAYS; w.target = U_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== sv/lir_seq.sv =====
// Microcode sequencer: step counter, control table lookup, waits and conditional jumps.
module lir_seq
  import lir_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  stat_t stat_i,
  output ctl_t  ctl_o
);

  logic [UPC_W-1:0] upc_q, upc_d;
  uword_t           word;
  logic             go;
  logic             jump;

  always_comb begin
    word = ucode_rom(upc_q);
    unique case (word.wt)
      W_IN:    go = in_valid_i;
      W_OUT:   go = !stat_i.out_busy;
      default: go = 1'b1;
    endcase
    unique case (word.jc)
      J_ALWAYS: jump = 1'b1;
      J_HAVE:   jump = stat_i.have_prev;
      J_DONE:   jump = stat_i.done;
      default:  jump = 1'b0;
    endcase
    if (!go) begin
      upc_d = upc_q;
    end else if (jump) begin
      upc_d = word.target;
    end else begin
      upc_d = upc_q + UPC_W'(1);
    end
    ctl_o        = go ? word.ctl : '0;
    ctl_o.in_rdy = word.ctl.in_rdy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_WAIT;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ===== sv/lir_datapath.sv =====
// Resampler datapath: config registers, frame store, phase, multipliers, output register.
module lir_datapath
  import lir_pkg::*;
#(
  parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ctl_t                           ctl_i,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [RATE_W-1:0]              cfg_data_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_0_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_1_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_0_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_1_o,
  output logic                           last_o,
  output stat_t                          stat_o
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int PF   = PHASE_FRAC_BITS;
  localparam int PSW  = PF + 5;
  localparam int PHW  = ((PSW > RATE_W) ? PSW : RATE_W) + 1;
  localparam int PRW  = SW + PF + 2;
  localparam logic [PHW-1:0] ONE = PHW'(1) << PF;

  logic [RATE_W-1:0]    rate_q;
  logic [CHAN_W-1:0]    chan_q;
  logic signed [SW-1:0] cur0_q, cur1_q, prev0_q, prev1_q;
  logic                 have_q;
  logic [PSW-1:0]       phase_q;
  logic [PHW-1:0]       ph_q, ph_next;
  logic [CNT_W-1:0]     n_q;
  logic signed [SW:0]   diff0_q, diff1_q, diff0_d, diff1_d;
  logic signed [PRW-1:0] prod0_q, prod1_q, sh0, sh1;
  logic signed [PF:0]   frac_s;
  logic signed [SW-1:0] o0, o1;
  logic                 mono, ph_ge, last_d;
  logic                 out_valid_q, last_q;
  logic signed [SW-1:0] out0_q, out1_q;

  always_comb begin
    mono    = (chan_q == CHAN_MONO);
    ph_ge   = (ph_q >= ONE);
    ph_next = ph_q + PHW'(rate_q);
    last_d  = (ph_next >= ONE) || (n_q == CNT_W'(MAX_OUT - 1));
    diff0_d = $signed({cur0_q[SW-1], cur0_q}) - $signed({prev0_q[SW-1], prev0_q});
    diff1_d = $signed({cur1_q[SW-1], cur1_q}) - $signed({prev1_q[SW-1], prev1_q});
    frac_s  = $signed({1'b0, ph_q[PF-1:0]});
    sh0     = prod0_q >>> PF;
    sh1     = prod1_q >>> PF;
    o0      = prev0_q + sh0[SW-1:0];
    o1      = mono ? '0 : prev1_q + sh1[SW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= RATE_RST;
      chan_q      <= CHAN_RST;
      prev0_q     <= '0;
      prev1_q     <= '0;
      have_q      <= 1'b0;
      phase_q     <= '0;
      ph_q        <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == REG_RATE_STEP) begin
        rate_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == REG_CHANNELS_USED) begin
        chan_q <= cfg_data_i[CHAN_W-1:0];
      end
      if (ctl_i.ld_prev) begin
        prev0_q <= cur0_q;
        prev1_q <= cur1_q;
      end
      if (ctl_i.set_have) begin
        have_q <= 1'b1;
      end
      if (ctl_i.init_ph) begin
        ph_q <= PHW'(phase_q);
        n_q  <= '0;
      end else if (ctl_i.emit) begin
        ph_q <= ph_next;
        n_q  <= n_q + CNT_W'(1);
      end
      if (ctl_i.fin) begin
        phase_q <= ph_ge ? PSW'(ph_q - ONE) : '0;
      end
      if (ctl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_cur) begin
      cur0_q <= sample_0_i;
      cur1_q <= sample_1_i;
    end
    if (ctl_i.ld_diff) begin
      diff0_q <= diff0_d;
      diff1_q <= diff1_d;
    end
    if (ctl_i.ld_prod) begin
      prod0_q <= diff0_q * frac_s;
      prod1_q <= diff1_q * frac_s;
    end
    if (ctl_i.emit) begin
      out0_q <= o0;
      out1_q <= o1;
      last_q <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_0_o          = out0_q;
  assign out_1_o          = out1_q;
  assign last_o           = last_q;
  assign stat_o.have_prev = have_q;
  assign stat_o.done      = ph_ge || (n_q == CNT_W'(MAX_OUT));
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;
  assign stat_o.n         = n_q;

endmodule

// ===== sv/linear_interp_resampler_top.sv =====
// Top level of the linear interpolation sample-rate converter.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | input     | in_valid_i/in_ready_o | sample_0_i, sample_1_i
//  out     | output    | out_valid_o/out_ready_i | out_0_o, out_1_o, last_o
//  cfg     | input     | cfg_we_i (no wait)    | cfg_idx_i, cfg_data_i
//
// First frame: wait and load. Later frame with n results: wait, diff, n passes
// of the microcode loop test/multiply/emit around the shared per-channel multipliers.
// Reset clears the stored frame, phase and config to defaults; no clearing pass.
// A stalled output holds the emit step; a new frame is taken only between frames,
// while the last result may still wait in the output register.
module linear_interp_resampler_top
  import lir_pkg::*;
#(
  parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [RATE_W-1:0]              cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_0_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_1_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] out_0_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_1_o,
  output logic                           last_o
);

  ctl_t  ctl;
  stat_t stat;

  lir_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  lir_datapath #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_0_i  (sample_0_i),
    .sample_1_i  (sample_1_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_0_o     (out_0_o),
    .out_1_o     (out_1_o),
    .last_o      (last_o),
    .stat_o      (stat)
  );

  assign in_ready_o = ctl.in_rdy;

  a_one_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("frame transfer not followed by busy sequencer");

  a_no_out_before_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat.have_prev |-> !out_valid_o)
    else $error("result before any frame stored");

  a_out_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.n <= CNT_W'(MAX_OUT))
    else $error("result count per frame exceeds limit");

  a_emit_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.emit |-> !stat.out_busy)
    else $error("emit while output register blocked");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the linear interpolation sample-rate converter.
`timescale 1ns / 1ps

module tb_top;
  import lir_pkg::*;

  localparam int SW             = SAMPLE_WIDTH_DEF;
  localparam int FB             = PHASE_FRAC_BITS_DEF;
  localparam int PH_W           = FB + 5;
  localparam int SETTLE         = 3 * MAX_OUT + 8;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int TIMEOUT_NS     = 400000;
  localparam int RAND_PHASES    = 6;
  localparam int RAND_FRAMES    = 13;

  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam longint unsigned ONE = longint'(1) << FB;

  typedef struct {
    logic signed [SW-1:0] s0;
    logic signed [SW-1:0] s1;
    int unsigned          gap;
  } frame_t;

  typedef struct {
    logic signed [SW-1:0] o0;
    logic signed [SW-1:0] o1;
    logic                 last;
  } sample_out_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [RATE_W-1:0]    cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic signed [SW-1:0] sample_0_i  = '0;
  logic signed [SW-1:0] sample_1_i  = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [SW-1:0] out_0_o;
  logic signed [SW-1:0] out_1_o;
  logic                 last_o;

  // shadow of the converter state and registers
  logic [RATE_W-1:0]    rate_q;
  logic [CHAN_W-1:0]    chans_q;
  logic signed [SW-1:0] prev0_q;
  logic signed [SW-1:0] prev1_q;
  logic [PH_W-1:0]      phase_q;
  logic                 have_prev_q;

  frame_t      frame_q[$];
  sample_out_t interp_q[$];

  int unsigned tx_wait;
  int unsigned rx_wait;
  int unsigned hold_cnt;
  bit          tx_burst;
  bit          rx_burst;
  bit          squeeze_req;
  bit          squeeze_done;
  int          err_cnt;
  int          frames_in;
  int          outs_seen;
  int          reg_writes;
  int          settings;

  linear_interp_resampler_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_0_i  (sample_0_i),
    .sample_1_i  (sample_1_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_0_o     (out_0_o),
    .out_1_o     (out_1_o),
    .last_o      (last_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic signed [SW-1:0] lerp(input logic signed [SW-1:0] p,
                                                input logic signed [SW-1:0] c,
                                                input logic [FB-1:0] f);
    longint d;
    longint prod;
    d    = longint'(c) - longint'(p);
    prod = d * longint'(f);
    return SW'(longint'(p) + (prod >>> FB));
  endfunction

  task automatic interp_frame(input logic signed [SW-1:0] c0, input logic signed [SW-1:0] c1);
    longint unsigned ph;
    int              n;
    sample_out_t     r;
    logic            mono;
    ph   = longint'(phase_q);
    n    = 0;
    mono = (chans_q == CHAN_MONO);
    if (!have_prev_q) begin
      have_prev_q = 1'b1;
    end else begin
      while (ph < ONE && n < MAX_OUT) begin
        r.o0   = lerp(prev0_q, c0, ph[FB-1:0]);
        r.o1   = mono ? '0 : lerp(prev1_q, c1, ph[FB-1:0]);
        r.last = ((ph + longint'(rate_q)) >= ONE) || (n == MAX_OUT - 1);
        interp_q.push_back(r);
        n++;
        ph += longint'(rate_q);
      end
      if (ph < ONE) ph = ONE;
      phase_q = PH_W'(ph - ONE);
    end
    prev0_q = c0;
    prev1_q = c1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drv
    frame_t nxt;
    logic   vld_nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_0_i <= '0;
      sample_1_i <= '0;
      tx_wait    <= 0;
    end else begin
      vld_nxt = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        interp_frame(sample_0_i, sample_1_i);
        frames_in++;
        vld_nxt = 1'b0;
      end
      if (!vld_nxt && frame_q.size() != 0) begin
        if (tx_wait < frame_q[0].gap) begin
          tx_wait <= tx_wait + 1;
        end else begin
          nxt = frame_q.pop_front();
          sample_0_i <= nxt.s0;
          sample_1_i <= nxt.s1;
          vld_nxt = 1'b1;
          tx_wait <= 0;
        end
      end
      in_valid_i <= vld_nxt;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : mon
    sample_out_t want;
    logic        rdy_nxt;
    int unsigned wait_nxt;
    if (!rst_ni) begin
      out_ready_i  <= 1'b0;
      rx_wait      <= 0;
      hold_cnt     <= 0;
      squeeze_done <= 1'b0;
    end else begin
      wait_nxt = rx_wait;
      if (out_valid_o && out_ready_i) begin
        outs_seen++;
        if (interp_q.size() == 0) begin
          $error("unexpected result: out_0=%0d out_1=%0d last=%0b", out_0_o, out_1_o, last_o);
          err_cnt++;
        end else begin
          want = interp_q.pop_front();
          if (out_0_o !== want.o0) begin
            $error("out_0: expected %0d, got %0d", want.o0, out_0_o);
            err_cnt++;
          end
          if (out_1_o !== want.o1) begin
            $error("out_1: expected %0d, got %0d", want.o1, out_1_o);
            err_cnt++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_o);
            err_cnt++;
          end
        end
        wait_nxt = rx_burst ? 0 : $urandom_range(0, 5);
        rdy_nxt  = (wait_nxt == 0);
      end else if (rx_wait > 0) begin
        wait_nxt = rx_wait - 1;
        rdy_nxt  = (wait_nxt == 0);
      end else begin
        rdy_nxt = 1'b1;
      end
      // long receiver stall so the converter backs up into its input
      if (squeeze_req && !squeeze_done) begin
        hold_cnt     <= SQUEEZE_CYCLES;
        squeeze_done <= 1'b1;
        rdy_nxt = 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        rdy_nxt = 1'b0;
      end
      out_ready_i <= rdy_nxt;
      rx_wait     <= wait_nxt;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_RATE_STEP:     rate_q = val;
      REG_CHANNELS_USED: chans_q = val[CHAN_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic wait_drained();
    while (frame_q.size() != 0 || in_valid_i || interp_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic new_setting(input logic [RATE_W-1:0] rate, input logic [CHAN_W-1:0] chans,
                             input bit tx_b, input bit rx_b);
    wait_drained();
    write_reg(REG_RATE_STEP, rate);
    write_reg(REG_CHANNELS_USED, RATE_W'(chans));
    @(negedge clk_i);
    tx_burst = tx_b;
    rx_burst = rx_b;
    settings++;
  endtask

  task automatic push_frame(input logic signed [SW-1:0] s0, input logic signed [SW-1:0] s1);
    frame_t f;
    f.s0  = s0;
    f.s1  = s1;
    f.gap = tx_burst ? 0 : $urandom_range(0, 5);
    frame_q.push_back(f);
  endtask

  function automatic logic signed [SW-1:0] pick_sample(input bit edgy);
    logic [1:0] k;
    k = 2'($urandom_range(0, 3));
    if (!edgy) return SW'($urandom());
    case (k)
      2'd0:    return S_MAX;
      2'd1:    return S_MIN;
      2'd2:    return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 4))
      0:       return RATE_W'($urandom_range(4096, 1048576));
      1:       return RATE_W'($urandom_range(20000, 70000));
      2:       return RATE_W'($urandom_range(65536, 200000));
      3:       return RATE_W'($urandom_range(4096, 16000));
      default: return RATE_W'($urandom_range(0, 4095));
    endcase
  endfunction

  initial begin : stim
    bit edgy;
    rate_q      = RATE_RST;
    chans_q     = CHAN_RST;
    prev0_q     = '0;
    prev1_q     = '0;
    phase_q     = '0;
    have_prev_q = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // first frame only primes the history
    new_setting(RATE_RST, CHAN_RST, 1'b0, 1'b0);
    push_frame('0, '0);
    push_frame(S_MAX, S_MIN);
    push_frame(S_MIN, S_MAX);
    push_frame('1, SW'(1));

    // sixteen outputs per frame across full-scale steps, one channel
    new_setting(RATE_W'(4096), CHAN_MONO, 1'b0, 1'b0);
    push_frame(S_MAX, S_MIN);
    push_frame(S_MIN, S_MAX);
    push_frame(S_MAX, S_MAX);

    // step below the output limit: phase forced to one
    new_setting(RATE_W'(1000), CHAN_W'(3), 1'b1, 1'b0);
    push_frame(S_MIN, S_MIN);
    push_frame(SW'(12345), -SW'(12345));

    // heavy decimation: most frames give nothing
    new_setting(RATE_W'(1048576), CHAN_W'(0), 1'b0, 1'b1);
    push_frame(S_MAX, '0);
    push_frame(S_MIN, '1);
    push_frame('0, S_MAX);
    push_frame('1, S_MIN);
    push_frame(SW'(100), -SW'(100));
    push_frame(S_MAX, S_MAX);

    new_setting(RATE_W'(43691), CHAN_RST, 1'b0, 1'b0);
    push_frame(S_MIN, S_MAX);
    push_frame(S_MAX, S_MIN);
    push_frame('1, '1);
    push_frame(SW'(1), '0);
    push_frame(S_MAX, S_MIN);
    push_frame(S_MIN, S_MIN);

    for (int p = 0; p < RAND_PHASES; p++) begin
      new_setting(pick_rate(), CHAN_W'($urandom_range(0, 3)), (p % 3) == 1, (p % 3) == 2);
      for (int i = 0; i < RAND_FRAMES; i++) begin
        edgy = ($urandom_range(0, 7) == 0);
        push_frame(pick_sample(edgy), pick_sample(edgy));
      end
      if (p == 1) squeeze_req = 1'b1;
    end

    wait_drained();
    if (interp_q.size() != 0) begin
      $error("%0d expected results never arrived", interp_q.size());
      err_cnt++;
    end
    $display("Run covered %0d frames, %0d output samples, %0d register settings (%0d writes)",
             frames_in, outs_seen, settings, reg_writes);
    if (err_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ===== linear_interp_resampler_top.f =====
sv/lir_pkg.sv
sv/lir_seq.sv
sv/lir_datapath.sv
sv/linear_interp_resampler_top.sv
tb/tb_top.sv
